/* hdl/cmfr_pkg.sv */
`timescale 1ns / 1ps
// Package for the CAN multi-frame reassembler: widths, frame type and
// status codes, and the control result struct. No dependencies.
package cmfr_pkg;

    localparam int ID_W    = 29;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 28;
    localparam int CNT_W   = 3;
    localparam int SEQ_W   = 5;
    localparam int N_LANES = 7;
    localparam int N_DATA  = 8;
    localparam int FF_LANES = 4;

    localparam logic [3:0] FT_SINGLE = 4'h0;
    localparam logic [3:0] FT_FIRST  = 4'h1;
    localparam logic [3:0] FT_CONSEC = 4'h2;

    localparam logic [SEQ_W-1:0] SEQ_IDLE = SEQ_W'(16);

    typedef enum logic [2:0] {
        ST_SINGLE  = 3'd0,
        ST_FIRST   = 3'd1,
        ST_CONSEC  = 3'd2,
        ST_SEQ_ERR = 3'd3,
        ST_FOREIGN = 3'd4,
        ST_IGNORED = 3'd5
    } t_status;

    typedef struct packed {
        t_status              status;
        logic                 done;
        logic [LEN_W-1:0]     offset;
        logic [CNT_W-1:0]     count;
        logic                 sel_ff;
        logic [LEN_W-1:0]     total_size;
    } t_ctrl_res;

endpackage

/* hdl/cmfr_cfg_if.sv */
`timescale 1ns / 1ps
// Configuration write channel: valid/ready plus expected identifier word.
// Depends on cmfr_pkg.
interface cmfr_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [cmfr_pkg::ID_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/cmfr_frame_if.sv */
`timescale 1ns / 1ps
// Input channel: one CAN frame word (identifier and eight data bytes).
// Depends on cmfr_pkg.
interface cmfr_frame_if;
    logic                         valid;
    logic                         ready;
    logic [cmfr_pkg::ID_W-1:0]    frame_id;
    logic [cmfr_pkg::BYTE_W-1:0]  data0;
    logic [cmfr_pkg::BYTE_W-1:0]  data1;
    logic [cmfr_pkg::BYTE_W-1:0]  data2;
    logic [cmfr_pkg::BYTE_W-1:0]  data3;
    logic [cmfr_pkg::BYTE_W-1:0]  data4;
    logic [cmfr_pkg::BYTE_W-1:0]  data5;
    logic [cmfr_pkg::BYTE_W-1:0]  data6;
    logic [cmfr_pkg::BYTE_W-1:0]  data7;

    modport source (output valid, output frame_id, output data0, output data1,
                    output data2, output data3, output data4, output data5,
                    output data6, output data7, input ready);
    modport sink   (input valid, input frame_id, input data0, input data1,
                    input data2, input data3, input data4, input data5,
                    input data6, input data7, output ready);
endinterface

/* hdl/cmfr_result_if.sv */
`timescale 1ns / 1ps
// Output channel: one reassembly result word per frame.
// Depends on cmfr_pkg.
interface cmfr_result_if;
    logic                         valid;
    logic                         ready;
    logic [2:0]                   status;
    logic                         done_res;
    logic [cmfr_pkg::LEN_W-1:0]   offset;
    logic [cmfr_pkg::CNT_W-1:0]   count;
    logic [cmfr_pkg::BYTE_W-1:0]  out_byte0;
    logic [cmfr_pkg::BYTE_W-1:0]  out_byte1;
    logic [cmfr_pkg::BYTE_W-1:0]  out_byte2;
    logic [cmfr_pkg::BYTE_W-1:0]  out_byte3;
    logic [cmfr_pkg::BYTE_W-1:0]  out_byte4;
    logic [cmfr_pkg::BYTE_W-1:0]  out_byte5;
    logic [cmfr_pkg::BYTE_W-1:0]  out_byte6;
    logic [cmfr_pkg::LEN_W-1:0]   total_size;

    modport source (output valid, output status, output done_res, output offset,
                    output count, output out_byte0, output out_byte1,
                    output out_byte2, output out_byte3, output out_byte4,
                    output out_byte5, output out_byte6, output total_size,
                    input ready);
    modport sink   (input valid, input status, input done_res, input offset,
                    input count, input out_byte0, input out_byte1,
                    input out_byte2, input out_byte3, input out_byte4,
                    input out_byte5, input out_byte6, input total_size,
                    output ready);
endinterface

/* hdl/cmfr_lane.sv */
`timescale 1ns / 1ps
// One payload byte lane: picks the frame byte for its position and blanks
// it past the delivered count. Depends on cmfr_pkg.
module cmfr_lane (
    input  logic [cmfr_pkg::CNT_W-1:0]  i_lane,
    input  logic [cmfr_pkg::CNT_W-1:0]  i_count,
    input  logic                        i_sel_ff,
    input  logic [cmfr_pkg::BYTE_W-1:0] i_byte_sf,
    input  logic [cmfr_pkg::BYTE_W-1:0] i_byte_ff,
    output logic [cmfr_pkg::BYTE_W-1:0] o_byte
);

    always_comb begin
        if (i_lane < i_count) begin
            o_byte = i_sel_ff ? i_byte_ff : i_byte_sf;
        end else begin
            o_byte = '0;
        end
    end

endmodule

/* hdl/cmfr_ctrl.sv */
`timescale 1ns / 1ps
// Reassembly control: expected identifier register, sequence and length
// tracking, per-frame status/count/offset decision. Depends on cmfr_pkg.
module cmfr_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [cmfr_pkg::ID_W-1:0]    i_cfg_data,
    input  logic                         i_accept,
    input  logic [cmfr_pkg::ID_W-1:0]    i_frame_id,
    input  logic [cmfr_pkg::BYTE_W-1:0]  i_data0,
    input  logic [cmfr_pkg::BYTE_W-1:0]  i_data1,
    input  logic [cmfr_pkg::BYTE_W-1:0]  i_data2,
    input  logic [cmfr_pkg::BYTE_W-1:0]  i_data3,
    output cmfr_pkg::t_ctrl_res          o_res
);

    logic [cmfr_pkg::ID_W-1:0]   r_expected_id;
    logic [cmfr_pkg::SEQ_W-1:0]  r_seq, n_seq;
    logic [cmfr_pkg::LEN_W-1:0]  r_rcv, n_rcv;
    logic [cmfr_pkg::LEN_W-1:0]  r_len, n_len;

    logic [3:0]                  w_type;
    logic [3:0]                  w_low;
    logic [cmfr_pkg::LEN_W-1:0]  w_remaining;
    logic [cmfr_pkg::CNT_W-1:0]  w_cnt_cf;
    logic [cmfr_pkg::LEN_W-1:0]  w_ff_len;
    logic [cmfr_pkg::CNT_W-1:0]  w_cnt_ff;

    assign w_type      = i_data0[7:4];
    assign w_low       = i_data0[3:0];
    assign w_remaining = r_len - r_rcv;
    assign w_cnt_cf    = (w_remaining < cmfr_pkg::LEN_W'(7)) ?
                         w_remaining[cmfr_pkg::CNT_W-1:0] : cmfr_pkg::CNT_W'(7);
    assign w_ff_len    = {w_low, i_data1, i_data2, i_data3};
    assign w_cnt_ff    = (w_ff_len < cmfr_pkg::LEN_W'(cmfr_pkg::FF_LANES)) ?
                         w_ff_len[cmfr_pkg::CNT_W-1:0] :
                         cmfr_pkg::CNT_W'(cmfr_pkg::FF_LANES);

    always_comb begin
        n_seq            = r_seq;
        n_rcv            = r_rcv;
        n_len            = r_len;
        o_res.status     = cmfr_pkg::ST_IGNORED;
        o_res.done       = 1'b0;
        o_res.offset     = '0;
        o_res.count      = '0;
        o_res.sel_ff     = 1'b0;
        if (i_frame_id != r_expected_id) begin
            o_res.status = cmfr_pkg::ST_FOREIGN;
        end else begin
            case (w_type)
                cmfr_pkg::FT_SINGLE: begin
                    if (w_low != 4'h0) begin
                        o_res.count  = w_low[3] ? cmfr_pkg::CNT_W'(7) : w_low[2:0];
                        o_res.status = cmfr_pkg::ST_SINGLE;
                        o_res.done   = 1'b1;
                        n_seq        = cmfr_pkg::SEQ_IDLE;
                    end
                end
                cmfr_pkg::FT_FIRST: begin
                    n_len        = w_ff_len;
                    o_res.count  = w_cnt_ff;
                    o_res.sel_ff = 1'b1;
                    o_res.status = cmfr_pkg::ST_FIRST;
                    n_rcv        = cmfr_pkg::LEN_W'(w_cnt_ff);
                    if (w_ff_len <= cmfr_pkg::LEN_W'(cmfr_pkg::FF_LANES)) begin
                        o_res.done = 1'b1;
                        n_seq      = cmfr_pkg::SEQ_IDLE;
                    end else begin
                        n_seq      = '0;
                    end
                end
                cmfr_pkg::FT_CONSEC: begin
                    if (r_seq[cmfr_pkg::SEQ_W-1] || w_low != r_seq[3:0] ||
                        r_rcv >= r_len) begin
                        o_res.status = cmfr_pkg::ST_SEQ_ERR;
                    end else begin
                        o_res.count  = w_cnt_cf;
                        o_res.offset = r_rcv;
                        o_res.status = cmfr_pkg::ST_CONSEC;
                        n_rcv        = r_rcv + cmfr_pkg::LEN_W'(w_cnt_cf);
                        if (w_remaining <= cmfr_pkg::LEN_W'(7)) begin
                            o_res.done = 1'b1;
                            n_seq      = cmfr_pkg::SEQ_IDLE;
                        end else begin
                            n_seq      = {1'b0, r_seq[3:0] + 4'h1};
                        end
                    end
                end
                default: begin
                    o_res.status = cmfr_pkg::ST_IGNORED;
                end
            endcase
        end
        o_res.total_size = n_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id <= '0;
            r_seq         <= cmfr_pkg::SEQ_IDLE;
            r_rcv         <= '0;
            r_len         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_expected_id <= i_cfg_data;
            end
            if (i_accept) begin
                r_seq <= n_seq;
                r_rcv <= n_rcv;
                r_len <= n_len;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_rcv_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_seq[cmfr_pkg::SEQ_W-1] |-> (r_rcv < r_len))
        else $error("active reception with bytes_received not below length");

    a_seq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq[cmfr_pkg::SEQ_W-1] |-> (r_seq == cmfr_pkg::SEQ_IDLE))
        else $error("sequence register holds an undefined idle code");

    a_done_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_res.done) |=> (r_seq == cmfr_pkg::SEQ_IDLE))
        else $error("completed package did not return to idle");
`endif

endmodule

/* hdl/can_multiframe_reassembler.sv */
`timescale 1ns / 1ps
// CAN multi-frame reassembler (ISO-TP style receive). Every accepted frame
// yields exactly one result word in the next cycle, held in an output
// register; a new frame is taken every cycle unless that register holds a
// word the sink has not taken. Seven byte lanes pick the payload bytes in
// parallel and the control unit decides status, count and offset in the
// same cycle. Depends on cmfr_pkg, the channel interfaces, cmfr_ctrl and
// cmfr_lane.
module can_multiframe_reassembler (
    input  logic               i_clk,
    input  logic               i_rst_n,
    cmfr_cfg_if.sink           i_cfg,
    cmfr_frame_if.sink         i_frame,
    cmfr_result_if.source      o_result
);

    cmfr_pkg::t_ctrl_res          w_res;
    logic                         w_accept;
    logic [cmfr_pkg::BYTE_W-1:0]  w_data [cmfr_pkg::N_DATA];
    logic [cmfr_pkg::BYTE_W-1:0]  w_byte_sf [cmfr_pkg::N_LANES];
    logic [cmfr_pkg::BYTE_W-1:0]  w_byte_ff [cmfr_pkg::N_LANES];
    logic [cmfr_pkg::BYTE_W-1:0]  w_lane [cmfr_pkg::N_LANES];

    logic                         r_valid;
    logic [2:0]                   r_status;
    logic                         r_done;
    logic [cmfr_pkg::LEN_W-1:0]   r_offset;
    logic [cmfr_pkg::CNT_W-1:0]   r_count;
    logic [cmfr_pkg::BYTE_W-1:0]  r_bytes [cmfr_pkg::N_LANES];
    logic [cmfr_pkg::LEN_W-1:0]   r_total;

    assign i_cfg.ready   = 1'b1;
    assign i_frame.ready = !r_valid || o_result.ready;
    assign w_accept      = i_frame.valid && i_frame.ready;

    assign w_data[0] = i_frame.data0;
    assign w_data[1] = i_frame.data1;
    assign w_data[2] = i_frame.data2;
    assign w_data[3] = i_frame.data3;
    assign w_data[4] = i_frame.data4;
    assign w_data[5] = i_frame.data5;
    assign w_data[6] = i_frame.data6;
    assign w_data[7] = i_frame.data7;

    cmfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg.valid && i_cfg.ready),
        .i_cfg_data (i_cfg.data),
        .i_accept   (w_accept),
        .i_frame_id (i_frame.frame_id),
        .i_data0    (i_frame.data0),
        .i_data1    (i_frame.data1),
        .i_data2    (i_frame.data2),
        .i_data3    (i_frame.data3),
        .o_res      (w_res)
    );

    for (genvar k = 0; k < cmfr_pkg::N_LANES; k++) begin : g_lane
        assign w_byte_sf[k] = w_data[k+1];
        if (k < cmfr_pkg::FF_LANES) begin : g_ff
            assign w_byte_ff[k] = w_data[k+cmfr_pkg::FF_LANES];
        end else begin : g_noff
            assign w_byte_ff[k] = '0;
        end
        cmfr_lane u_lane (
            .i_lane    (cmfr_pkg::CNT_W'(k)),
            .i_count   (w_res.count),
            .i_sel_ff  (w_res.sel_ff),
            .i_byte_sf (w_byte_sf[k]),
            .i_byte_ff (w_byte_ff[k]),
            .o_byte    (w_lane[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= w_res.status;
            r_done   <= w_res.done;
            r_offset <= w_res.offset;
            r_count  <= w_res.count;
            r_bytes  <= w_lane;
            r_total  <= w_res.total_size;
        end
    end

    assign o_result.valid      = r_valid;
    assign o_result.status     = r_status;
    assign o_result.done_res   = r_done;
    assign o_result.offset     = r_offset;
    assign o_result.count      = r_count;
    assign o_result.out_byte0  = r_bytes[0];
    assign o_result.out_byte1  = r_bytes[1];
    assign o_result.out_byte2  = r_bytes[2];
    assign o_result.out_byte3  = r_bytes[3];
    assign o_result.out_byte4  = r_bytes[4];
    assign o_result.out_byte5  = r_bytes[5];
    assign o_result.out_byte6  = r_bytes[6];
    assign o_result.total_size = r_total;

`ifndef NO_ASSERTIONS
    a_done_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_done) |-> (r_status == cmfr_pkg::ST_SINGLE ||
            r_status == cmfr_pkg::ST_FIRST || r_status == cmfr_pkg::ST_CONSEC))
        else $error("completion flagged on a rejected frame");

    a_blank_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_count == '0) |-> (r_bytes[0] == '0 && r_bytes[6] == '0))
        else $error("payload bytes present with zero count");

    a_offset_consec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_offset != '0) |-> (r_status == cmfr_pkg::ST_CONSEC))
        else $error("nonzero offset outside a consecutive frame");
`endif

endmodule
